// File: hdl/ffha_pkg.sv
// Package with the item, table entry and status types of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int MAX_CHUNKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_FIT       = 3'd1,
    ST_FULL         = 3'd2,
    ST_BAD_RELEASE  = 3'd3,
    ST_NULL_RELEASE = 3'd4
  } status_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] payload_address;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        used;
  } entry_t;

endpackage
`default_nettype wire

// File: hdl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator with chunk table held in one synchronous memory.
// Flow: entries are scanned up to the hit and the result is loaded; a split moves later
// entries up and writes both parts; a release reads the next entry if any, writes the merged
// chunk and moves later entries down; a null release or an empty table goes to the result.
// One item is in work at a time; the single memory port pair sets the rate.
// Reset clears the state, chunk count, heap base and size and output valid; the table memory is not cleared.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int MAX_CHUNKS   = ffha_pkg::MAX_CHUNKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  ffha_pkg::in_item_t       in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output ffha_pkg::out_item_t            out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [31:0]                    cfg_data
);

  localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [31:0] HB = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] CMAX = CW'(MAX_CHUNKS);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RD   = 13'b0000000000010,
    S_CHK  = 13'b0000000000100,
    S_SPRD = 13'b0000000001000,
    S_SPWR = 13'b0000000010000,
    S_AW1  = 13'b0000000100000,
    S_AW2  = 13'b0000001000000,
    S_RNRD = 13'b0000010000000,
    S_RNCK = 13'b0000100000000,
    S_RMW  = 13'b0001000000000,
    S_SDRD = 13'b0010000000000,
    S_SDWR = 13'b0100000000000,
    S_RES  = 13'b1000000000000
  } state_t;

  ffha_pkg::entry_t mem [MAX_CHUNKS];
  ffha_pkg::entry_t rd_q;
  logic             we;
  logic [IW-1:0]    wa;
  logic [IW-1:0]    ra;
  ffha_pkg::entry_t wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  state_t           st_r, st_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    hit_r, hit_nxt;
  ffha_pkg::entry_t hent_r, hent_nxt;
  ffha_pkg::entry_t prev_r, prev_nxt;
  ffha_pkg::entry_t next_r, next_nxt;
  logic             pfree_r, pfree_nxt;
  logic             nfree_r, nfree_nxt;
  logic [1:0]       drop_r, drop_nxt;
  logic [31:0]      base_r, base_nxt;
  logic [31:0]      bytes_r, bytes_nxt;
  ffha_pkg::in_item_t  req_r, req_nxt;
  ffha_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  ffha_pkg::out_item_t out_r, out_nxt;

  logic        match;
  logic        split;
  logic [32:0] need;
  logic [31:0] msize;
  logic [IW-1:0] bidx;
  logic [1:0]  dsum;

  assign in_ready  = (st_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    need  = {1'b0, req_r.request_bytes} + {1'b0, HB} + 33'd1;
    split = ({1'b0, rd_q.size} >= need);
    if (req_r.opcode == ffha_pkg::OP_ALLOC) begin
      match = !rd_q.used && (req_r.request_bytes <= rd_q.size);
    end else begin
      match = ((base_r + rd_q.offset + HB) == req_r.release_address);
    end
    bidx  = pfree_r ? (hit_r - IW'(1)) : hit_r;
    msize = (pfree_r ? (prev_r.size + hent_r.size + HB) : hent_r.size)
          + (nfree_r ? (next_r.size + HB) : 32'd0);
    dsum  = {1'b0, pfree_r} + {1'b0, nfree_r};
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    hent_nxt      = hent_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    pfree_nxt     = pfree_r;
    nfree_nxt     = nfree_r;
    drop_nxt      = drop_r;
    base_nxt      = base_r;
    bytes_nxt     = bytes_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    ra            = idx_r[IW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == ffha_pkg::REG_HEAP_BASE || cfg_index == ffha_pkg::REG_HEAP_BYTES) begin
            if (cfg_index == ffha_pkg::REG_HEAP_BASE) begin
              base_nxt = cfg_data;
            end else begin
              bytes_nxt = cfg_data;
            end
            we        = 1'b1;
            wa        = '0;
            wd.offset = '0;
            wd.size   = bytes_nxt - HB;
            wd.used   = 1'b0;
            cnt_nxt   = (bytes_nxt < HB) ? CW'(0) : CW'(1);
          end
        end else if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
          res_nxt.payload_address = '0;
          if (in_data.opcode == ffha_pkg::OP_RELEASE && in_data.release_address == 32'd0) begin
            res_nxt.status = ffha_pkg::ST_NULL_RELEASE;
            st_nxt = S_RES;
          end else if (cnt_r == '0) begin
            res_nxt.status = (in_data.opcode == ffha_pkg::OP_ALLOC) ?
                             ffha_pkg::ST_NO_FIT : ffha_pkg::ST_BAD_RELEASE;
            st_nxt = S_RES;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ra     = idx_r[IW-1:0];
        st_nxt = S_CHK;
      end
      S_CHK: begin
        res_nxt.payload_address = '0;
        if (match) begin
          hit_nxt  = idx_r[IW-1:0];
          hent_nxt = rd_q;
          if (req_r.opcode == ffha_pkg::OP_ALLOC) begin
            if (split) begin
              if (cnt_r == CMAX) begin
                res_nxt.status = ffha_pkg::ST_FULL;
                st_nxt = S_RES;
              end else begin
                idx_nxt = cnt_r - CW'(1);
                st_nxt  = S_SPRD;
              end
            end else begin
              we      = 1'b1;
              wa      = idx_r[IW-1:0];
              wd      = rd_q;
              wd.used = 1'b1;
              res_nxt.payload_address = base_r + rd_q.offset + HB;
              res_nxt.status = ffha_pkg::ST_OK;
              st_nxt = S_RES;
            end
          end else begin
            pfree_nxt = (idx_r != '0) && !prev_r.used;
            if ((idx_r + CW'(1)) < cnt_r) begin
              idx_nxt = idx_r + CW'(1);
              st_nxt  = S_RNRD;
            end else begin
              nfree_nxt = 1'b0;
              st_nxt    = S_RMW;
            end
          end
        end else begin
          prev_nxt = rd_q;
          idx_nxt  = idx_r + CW'(1);
          if ((idx_r + CW'(1)) == cnt_r) begin
            res_nxt.status = (req_r.opcode == ffha_pkg::OP_ALLOC) ?
                             ffha_pkg::ST_NO_FIT : ffha_pkg::ST_BAD_RELEASE;
            st_nxt = S_RES;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_SPRD: begin
        if (idx_r > {1'b0, hit_r}) begin
          ra     = idx_r[IW-1:0];
          st_nxt = S_SPWR;
        end else begin
          st_nxt = S_AW1;
        end
      end
      S_SPWR: begin
        we      = 1'b1;
        wa      = IW'(idx_r + CW'(1));
        wd      = rd_q;
        idx_nxt = idx_r - CW'(1);
        st_nxt  = S_SPRD;
      end
      S_AW1: begin
        we        = 1'b1;
        wa        = hit_r + IW'(1);
        wd.offset = hent_r.offset + HB + req_r.request_bytes;
        wd.size   = hent_r.size - req_r.request_bytes - HB;
        wd.used   = 1'b0;
        st_nxt    = S_AW2;
      end
      S_AW2: begin
        we        = 1'b1;
        wa        = hit_r;
        wd.offset = hent_r.offset;
        wd.size   = req_r.request_bytes;
        wd.used   = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        res_nxt.payload_address = base_r + hent_r.offset + HB;
        res_nxt.status = ffha_pkg::ST_OK;
        st_nxt = S_RES;
      end
      S_RNRD: begin
        ra     = idx_r[IW-1:0];
        st_nxt = S_RNCK;
      end
      S_RNCK: begin
        next_nxt  = rd_q;
        nfree_nxt = !rd_q.used;
        st_nxt    = S_RMW;
      end
      S_RMW: begin
        we        = 1'b1;
        wa        = bidx;
        wd.offset = pfree_r ? prev_r.offset : hent_r.offset;
        wd.size   = msize;
        wd.used   = 1'b0;
        drop_nxt  = dsum;
        idx_nxt   = CW'(bidx) + CW'(1) + CW'(dsum);
        st_nxt    = S_SDRD;
      end
      S_SDRD: begin
        if (idx_r < cnt_r) begin
          ra     = idx_r[IW-1:0];
          st_nxt = S_SDWR;
        end else begin
          cnt_nxt = cnt_r - CW'(drop_r);
          res_nxt.payload_address = '0;
          res_nxt.status = ffha_pkg::ST_OK;
          st_nxt = S_RES;
        end
      end
      S_SDWR: begin
        we      = 1'b1;
        wa      = IW'(idx_r - CW'(drop_r));
        wd      = rd_q;
        idx_nxt = idx_r + CW'(1);
        st_nxt  = S_SDRD;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      base_r      <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    hent_r  <= hent_nxt;
    prev_r  <= prev_nxt;
    next_r  <= next_nxt;
    pfree_r <= pfree_nxt;
    nfree_r <= nfree_nxt;
    drop_r  <= drop_nxt;
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire
